@@ rtl/tard_pkg.sv @@
// ----------------------------------------------------------------------------
// tard_pkg
// Shared types and constants of the typed array record deframer.
// ----------------------------------------------------------------------------
package tard_pkg;

  localparam int unsigned TypeW  = 2;
  localparam int unsigned CountW = 32;
  localparam int unsigned IndexW = 35;

  localparam int unsigned QueueDepth = 2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_BAD_TYPE = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TypeW-1:0]  elem_type;
    logic [CountW-1:0] elem_count;
    logic [7:0]        data_byte;
    logic [IndexW-1:0] byte_index;
    logic              last;
  } tard_result_t;

endpackage

@@ rtl/tard_front.sv @@
// ----------------------------------------------------------------------------
// tard_front
// Record parser: decodes type byte and LEB128 count, tags payload bytes.
// ----------------------------------------------------------------------------
module tard_front #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic [7:0]            in_byte_i,
  output logic                  res_valid_o,
  output tard_pkg::tard_result_t res_o
);
  import tard_pkg::*;

  localparam int unsigned GroupSat = (COUNT_BITS + 6) / 7;
  localparam int unsigned GnW      = $clog2(GroupSat + 1);
  localparam int unsigned ShW      = $clog2(COUNT_BITS + 7);
  localparam int unsigned BlW      = (COUNT_BITS + 3 > 64) ? 64 : COUNT_BITS + 3;

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [7:0]            base_q;
  logic [1:0]            phase_q, phase_d;
  logic [TypeW-1:0]      cur_type_q, cur_type_d;
  logic [COUNT_BITS-1:0] count_acc_q, count_acc_d;
  logic [GnW-1:0]        group_num_q, group_num_d;
  logic [BlW-1:0]        bytes_left_q, bytes_left_d;
  logic [IndexW-1:0]     pos_q, pos_d;

  logic [7:0]            code;
  logic [6:0]            group;
  logic                  more;
  logic [ShW-1:0]        shamt;
  logic [COUNT_BITS+6:0] grp_ext;
  logic                  grp_ovf;
  logic                  size_ovf;
  logic [COUNT_BITS-1:0] acc_new;
  logic [GnW-1:0]        gn_new;
  logic                  fin;
  logic                  res_valid;
  tard_result_t          res;

  always_comb begin
    code    = in_byte_i - base_q;
    group   = in_byte_i[6:0];
    more    = in_byte_i[7];
    shamt   = ShW'(group_num_q) * ShW'(7);
    grp_ext = {{COUNT_BITS{1'b0}}, group} << shamt;
    if (group_num_q >= GnW'(GroupSat)) begin
      grp_ovf = (group != 7'd0);
      acc_new = count_acc_q;
      gn_new  = group_num_q;
    end else begin
      grp_ovf = |grp_ext[COUNT_BITS+6:COUNT_BITS];
      acc_new = count_acc_q | grp_ext[COUNT_BITS-1:0];
      gn_new  = group_num_q + GnW'(1);
    end
    size_ovf = 1'b0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (acc_new[i] && (i + int'(cur_type_q) >= 64)) begin
        size_ovf = 1'b1;
      end
    end
    fin = (bytes_left_q <= BlW'(1));
  end

  always_comb begin
    phase_d      = phase_q;
    cur_type_d   = cur_type_q;
    count_acc_d  = count_acc_q;
    group_num_d  = group_num_q;
    bytes_left_d = bytes_left_q;
    pos_d        = pos_q;
    res_valid    = 1'b0;
    res          = '0;
    res.kind     = KIND_PAYLOAD;
    unique case (phase_q)
      PH_COUNT: begin
        res.elem_type  = cur_type_q;
        res.last       = 1'b1;
        if (grp_ovf) begin
          phase_d        = PH_TYPE;
          res_valid      = 1'b1;
          res.kind       = KIND_OVERFLOW;
          res.elem_count = CountW'(count_acc_q);
        end else begin
          count_acc_d = acc_new;
          group_num_d = gn_new;
          if (!more) begin
            if (acc_new == '0) begin
              phase_d   = PH_TYPE;
              res_valid = 1'b1;
              res.kind  = KIND_EMPTY;
            end else if (size_ovf) begin
              phase_d        = PH_TYPE;
              res_valid      = 1'b1;
              res.kind       = KIND_OVERFLOW;
              res.elem_count = CountW'(acc_new);
            end else begin
              bytes_left_d = BlW'(acc_new) << cur_type_q;
              pos_d        = '0;
              phase_d      = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res.kind       = KIND_PAYLOAD;
        res.elem_type  = cur_type_q;
        res.elem_count = CountW'(count_acc_q);
        res.data_byte  = in_byte_i;
        res.byte_index = pos_q;
        res.last       = fin;
        bytes_left_d   = fin ? '0 : bytes_left_q - BlW'(1);
        pos_d          = pos_q + IndexW'(1);
        if (fin) begin
          phase_d = PH_TYPE;
        end
      end
      default: begin
        phase_d = PH_TYPE;
        if (code > 8'd3) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_TYPE;
          res.last  = 1'b1;
        end else begin
          cur_type_d   = code[TypeW-1:0];
          count_acc_d  = '0;
          group_num_d  = '0;
          bytes_left_d = '0;
          pos_d        = '0;
          phase_d      = PH_COUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      phase_q      <= PH_TYPE;
      cur_type_q   <= '0;
      count_acc_q  <= '0;
      group_num_q  <= '0;
      bytes_left_q <= '0;
      pos_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      if (in_valid_i) begin
        phase_q      <= phase_d;
        cur_type_q   <= cur_type_d;
        count_acc_q  <= count_acc_d;
        group_num_q  <= group_num_d;
        bytes_left_q <= bytes_left_d;
        pos_q        <= pos_d;
      end
    end
  end

  assign res_valid_o = in_valid_i & res_valid;
  assign res_o       = res;

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bytes_left_q != '0)
    else $error("payload phase with no bytes left");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind != KIND_PAYLOAD |-> res_o.last)
    else $error("non-payload result without last");

  a_last_ends_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> phase_q == PH_TYPE)
    else $error("record not closed after last result");

endmodule

@@ rtl/tard_fifo.sv @@
// ----------------------------------------------------------------------------
// tard_fifo
// Short result queue between the parser and the result port.
// ----------------------------------------------------------------------------
module tard_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_i,
  input  tard_pkg::tard_result_t wdata_i,
  output logic                   full_o,
  input  logic                   rd_i,
  output logic                   empty_o,
  output tard_pkg::tard_result_t rdata_o
);
  import tard_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  tard_result_t    mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i & ~full_o;
  assign do_rd   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("transfer into a full queue");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr && !do_rd |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not follow transfer");

endmodule

@@ rtl/typed_array_record_deframer.sv @@
// ----------------------------------------------------------------------------
// typed_array_record_deframer
// Typed array record parser with LEB128 element count, queue-style ports.
// ----------------------------------------------------------------------------
// one byte per cycle while the queue is not full; a result can be popped in the cycle after its byte is taken
// bytes without a result (most type and count bytes) emit nothing
// throughput set by the parser state update and the two-entry result queue
// reset clears the parser to expect a type byte, empties the queue, base = 0
// ----------------------------------------------------------------------------
module typed_array_record_deframer #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [1:0]  elem_type_o,
  output logic [31:0] elem_count_o,
  output logic [7:0]  data_byte_o,
  output logic [34:0] byte_index_o,
  output logic        last_o
);
  import tard_pkg::*;

  logic         in_valid;
  logic         res_valid;
  tard_result_t res;
  tard_result_t head;

  assign in_valid = push & ~full;

  tard_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid),
    .in_byte_i  (in_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tard_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (res_valid),
    .wdata_i(res),
    .full_o (full),
    .rd_i   (pop),
    .empty_o(empty),
    .rdata_o(head)
  );

  assign kind_o       = head.kind;
  assign elem_type_o  = head.elem_type;
  assign elem_count_o = head.elem_count;
  assign data_byte_o  = head.data_byte;
  assign byte_index_o = head.byte_index;
  assign last_o       = head.last;

endmodule
